[hw/rtl/ljc_pkg.sv]
// link jamming classifier: shared types, constants and register codes
// used by ljc_front, ljc_back and link_jamming_classifier_core
`timescale 1ns / 1ps

package ljc_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = 8 + $clog2(WINDOW_DEPTH);
	localparam int RSS_SUM_W    = 12 + $clog2(WINDOW_DEPTH);
	localparam int PDR_W        = SUM_W + 11;
	localparam int CMP_W        = 16 + CNT_W + 2;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCNT_W = 2;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 3;

	// reset values of the config registers
	localparam logic [10:0]        PDR_GOOD_RST     = 11'd922;
	localparam logic [10:0]        PDR_THR_RST      = 11'd768;
	localparam logic [11:0]        DROP_TOL_RST     = 12'd160;
	localparam logic [7:0]         PERSIST_RST      = 8'd3;
	localparam logic signed [11:0] INIT_BASELINE_RST = -12'sd800;

	// 0.9/0.1 averaging: floor(x / 10) via offset and reciprocal
	localparam logic [20:0] DIV_OFFSET = 21'd327680;
	localparam logic [16:0] DIV_RECIP  = 17'd104857;
	localparam logic [16:0] Q_OFFSET   = 17'd32768;

	typedef enum logic [0:0] {
		OP_PUSH     = 1'b0,
		OP_CLASSIFY = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_FADING  = 2'd1,
		ST_SUSPECT = 2'd2,
		ST_CONFIRM = 2'd3
	} status_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PDR_GOOD      = 3'd0,
		REG_PDR_THRESHOLD = 3'd1,
		REG_DROP_TOL      = 3'd2,
		REG_PERSIST       = 3'd3,
		REG_INIT_BASELINE = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		op_e                op;
		logic [10:0]        obs_pdr;
		logic signed [11:0] obs_rss;
		logic [7:0]         sent_count;
		logic [7:0]         recv_count;
	} item_t;

	typedef struct packed {
		logic [7:0]         sent;
		logic [7:0]         recv;
		logic signed [11:0] rss;
	} entry_t;

endpackage

[hw/rtl/ljc_front.sv]
// link jamming classifier front end: takes input transactions, decodes them
// and holds them in a two-entry queue for the back end; uses ljc_pkg
`timescale 1ns / 1ps

module ljc_front import ljc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // obs_pdr, obs_rss, sent_count, recv_count, pad
	input  logic                 s_axis_tuser,  // operation
	output item_t                q_item,
	output logic                 q_valid,
	input  logic                 q_ready
);

	item_t             queue_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             dec_item;
	logic              push;
	logic              pop;

	always_comb begin
		dec_item.op         = op_e'(s_axis_tuser);
		dec_item.obs_pdr    = s_axis_tdata[10:0];
		dec_item.obs_rss    = s_axis_tdata[22:11];
		dec_item.sent_count = s_axis_tdata[30:23];
		dec_item.recv_count = s_axis_tdata[38:31];
	end

	assign s_axis_tready = (count_q != QCNT_W'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_valid && q_ready;
	assign q_item        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/ljc_back.sv]
// link jamming classifier back end: window store, running sums, baseline,
// classify compares, config registers and output register; uses ljc_pkg
`timescale 1ns / 1ps

module ljc_back import ljc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                q_item,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output status_e              out_status,
	output logic [4:0]           out_fill
);

	entry_t                 win_q [WINDOW_DEPTH];
	logic [IDX_W-1:0]       write_slot_q;
	logic [CNT_W-1:0]       entry_count_q;
	logic [SUM_W-1:0]       sent_sum_q;
	logic [SUM_W-1:0]       recv_sum_q;
	logic signed [RSS_SUM_W-1:0] rss_sum_q;
	logic signed [15:0]     baseline_q;
	logic [7:0]             bad_run_q;

	logic [10:0]            pdr_good_q;
	logic [10:0]            pdr_thr_q;
	logic [11:0]            drop_tol_q;
	logic [7:0]             persist_q;

	logic                   out_valid_q;
	status_e                out_status_q;
	logic [4:0]             out_fill_q;

	logic                   take;
	logic                   full;
	entry_t                 evicted;
	entry_t                 new_entry;
	logic [SUM_W-1:0]       sent_sum_n;
	logic [SUM_W-1:0]       recv_sum_n;
	logic signed [RSS_SUM_W-1:0] rss_sum_n;
	logic [CNT_W-1:0]       entry_count_n;
	logic [IDX_W-1:0]       write_slot_n;

	logic signed [20:0]     avg_x;
	logic [19:0]            avg_y;
	logic [36:0]            avg_prod;
	logic [16:0]            avg_q0;
	logic [20:0]            avg_rem;
	logic [16:0]            avg_q;
	logic signed [15:0]     baseline_n;

	logic                   short_win;
	logic                   healthy;
	logic [PDR_W-1:0]       recv_scaled;
	logic [PDR_W-1:0]       thr_prod;
	logic signed [CMP_W-1:0] base_w;
	logic signed [CMP_W-1:0] cnt_w;
	logic signed [CMP_W-1:0] rss_w;
	logic signed [CMP_W-1:0] lhs;
	logic signed [CMP_W-1:0] rhs;
	logic                   fading;
	logic [7:0]             bad_run_inc;

	assign q_ready    = !out_valid_q || out_ready;
	assign take       = q_valid && q_ready;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_fill   = out_fill_q;

	// push path: evict the oldest entry once the window is full
	always_comb begin
		full                 = (entry_count_q == CNT_W'(WINDOW_DEPTH));
		evicted              = win_q[write_slot_q];
		new_entry.sent       = q_item.sent_count;
		new_entry.recv       = q_item.recv_count;
		new_entry.rss        = q_item.obs_rss;
		sent_sum_n           = sent_sum_q + SUM_W'(q_item.sent_count)
		                       - (full ? SUM_W'(evicted.sent) : '0);
		recv_sum_n           = recv_sum_q + SUM_W'(q_item.recv_count)
		                       - (full ? SUM_W'(evicted.recv) : '0);
		rss_sum_n            = rss_sum_q + RSS_SUM_W'(q_item.obs_rss)
		                       - (full ? RSS_SUM_W'(evicted.rss) : '0);
		entry_count_n        = full ? entry_count_q : entry_count_q + 1'b1;
		write_slot_n         = (write_slot_q == IDX_W'(WINDOW_DEPTH - 1)) ?
		                       '0 : write_slot_q + 1'b1;
	end

	// baseline = floor((9 * b + 16 * rss + 5) / 10), offset to stay positive
	always_comb begin
		avg_x    = (21'(baseline_q) <<< 3) + 21'(baseline_q)
		           + (21'(q_item.obs_rss) <<< 4) + 21'sd5;
		avg_y    = 20'(avg_x + $signed(DIV_OFFSET));
		avg_prod = 37'(avg_y) * 37'(DIV_RECIP);
		avg_q0   = avg_prod[36:20];
		avg_rem  = 21'(avg_y) - ((21'(avg_q0) << 3) + (21'(avg_q0) << 1));
		avg_q    = (avg_rem >= 21'd10) ? avg_q0 + 1'b1 : avg_q0;
		baseline_n = 16'(avg_q - Q_OFFSET);
	end

	// classify path: cross-multiplied ratio and drop compares
	always_comb begin
		short_win   = (entry_count_q < CNT_W'(WINDOW_DEPTH / 2));
		recv_scaled = PDR_W'({recv_sum_q, 10'b0});
		thr_prod    = PDR_W'(pdr_thr_q) * PDR_W'(sent_sum_q);
		healthy     = (sent_sum_q == '0) || (recv_scaled >= thr_prod);
		base_w      = CMP_W'(baseline_q);
		cnt_w       = CMP_W'({1'b0, entry_count_q});
		rss_w       = CMP_W'(rss_sum_q) <<< 4;
		lhs         = base_w * cnt_w - rss_w;
		rhs         = $signed(CMP_W'({drop_tol_q, 4'b0})) * cnt_w;
		fading      = (lhs > rhs);
		bad_run_inc = (bad_run_q == 8'hff) ? bad_run_q : bad_run_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (take && q_item.op == OP_PUSH) begin
			win_q[write_slot_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			entry_count_q <= '0;
			sent_sum_q    <= '0;
			recv_sum_q    <= '0;
			rss_sum_q     <= '0;
			baseline_q    <= {INIT_BASELINE_RST, 4'b0};
			bad_run_q     <= '0;
			pdr_good_q    <= PDR_GOOD_RST;
			pdr_thr_q     <= PDR_THR_RST;
			drop_tol_q    <= DROP_TOL_RST;
			persist_q     <= PERSIST_RST;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_NONE;
			out_fill_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PDR_GOOD:      pdr_good_q <= cfg_data[10:0];
					REG_PDR_THRESHOLD: pdr_thr_q  <= cfg_data[10:0];
					REG_DROP_TOL:      drop_tol_q <= cfg_data;
					REG_PERSIST:       persist_q  <= cfg_data[7:0];
					REG_INIT_BASELINE: baseline_q <= {cfg_data, 4'b0};
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				case (q_item.op)
					OP_PUSH: begin
						write_slot_q  <= write_slot_n;
						entry_count_q <= entry_count_n;
						sent_sum_q    <= sent_sum_n;
						recv_sum_q    <= recv_sum_n;
						rss_sum_q     <= rss_sum_n;
						if (q_item.obs_pdr >= pdr_good_q) begin
							baseline_q <= baseline_n;
						end
						out_status_q <= ST_NONE;
						out_fill_q   <= 5'(entry_count_n);
					end
					OP_CLASSIFY: begin
						out_fill_q <= 5'(entry_count_q);
						if (short_win) begin
							out_status_q <= ST_NONE;
						end else if (healthy) begin
							bad_run_q    <= '0;
							out_status_q <= ST_NONE;
						end else if (fading) begin
							out_status_q <= ST_FADING;
						end else begin
							bad_run_q    <= bad_run_inc;
							out_status_q <= (bad_run_inc >= persist_q) ?
							                ST_CONFIRM : ST_SUSPECT;
						end
					end
					default: out_status_q <= ST_NONE;
				endcase
			end
		end
	end

endmodule

[hw/rtl/link_jamming_classifier_core.sv]
// link jamming classifier top level: front queue and back end execution
// depends on ljc_pkg, ljc_front, ljc_back
//
//   channel   signals                         direction  payload
//   s_axis    tvalid tready tdata[39:0] tuser in         observation or classify request
//   m_axis    tvalid tready tdata[7:0]        out        status[1:0], fill_level[6:2]
//   cfg       cfg_we cfg_index cfg_data       in         register writes, no read-back
//
// one transaction per cycle sustained while the output is not stalled; the back end
// updates its window sums, baseline and bad-window counter as it takes each item.
// an accepted input is registered in the front queue and then in the output register.
// reset clears all control state and loads the register defaults and the baseline.
// a stalled output holds in the output register; the two-entry queue absorbs the
// input so s_axis_tready drops only once both entries are taken.
`timescale 1ns / 1ps

module link_jamming_classifier_core import ljc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // obs_pdr, obs_rss, sent_count, recv_count, pad
	input  logic                  s_axis_tuser,  // operation
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // status, fill_level, pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	item_t      q_item;
	logic       q_valid;
	logic       q_ready;
	status_e    out_status;
	logic [4:0] out_fill;

	ljc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_ready       (q_ready)
	);

	ljc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (q_item),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_fill   (out_fill)
	);

	assign m_axis_tdata = {1'b0, out_fill, out_status};

endmodule

[sim/tb_top.sv]
// self-checking testbench for link_jamming_classifier_core: directed and random
// push/classify traffic with bursty input, receiver stalls and register changes
// depends on ljc_pkg and link_jamming_classifier_core
`timescale 1ns / 1ps

module tb_top;
	import ljc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		status_e    status;
		logic [4:0] fill;
	} report_t;

	typedef enum int {SC_HEALTHY, SC_JAMMED, SC_FADING, SC_NOISE} scene_e;

	// predictor of the window, baseline and bad-window counter, plus the result store
	class link_scoreboard;
		int good_ratio, healthy_ratio, drop_tol, persist;
		int slot_sent[WINDOW_DEPTH];
		int slot_recv[WINDOW_DEPTH];
		int slot_rss[WINDOW_DEPTH];
		int wr_slot, fill, sent_total, recv_total, rss_total, baseline, bad_count;
		report_t expected_reports[$];
		int mismatches;
		int seen[4];

		function new();
			good_ratio    = PDR_GOOD_RST;
			healthy_ratio = PDR_THR_RST;
			drop_tol      = DROP_TOL_RST;
			persist       = PERSIST_RST;
			baseline      = int'(INIT_BASELINE_RST) * 16;
			wr_slot = 0; fill = 0; sent_total = 0; recv_total = 0; rss_total = 0;
			bad_count = 0; mismatches = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PDR_GOOD:      good_ratio = val[10:0];
				REG_PDR_THRESHOLD: healthy_ratio = val[10:0];
				REG_DROP_TOL:      drop_tol = val;
				REG_PERSIST:       persist = val[7:0];
				REG_INIT_BASELINE: baseline = int'($signed(val)) * 16;
				default: ;
			endcase
		endfunction

		// floor of x / 10, ties of the rounding offset handled by the caller
		function int floor_div10(int x);
			if (x >= 0)
				return x / 10;
			return -((-x + 9) / 10);
		endfunction

		function void apply_push(item_t it);
			int rss;
			rss = int'($signed(it.obs_rss));
			if (fill >= WINDOW_DEPTH) begin
				sent_total -= slot_sent[wr_slot];
				recv_total -= slot_recv[wr_slot];
				rss_total  -= slot_rss[wr_slot];
			end else begin
				fill++;
			end
			slot_sent[wr_slot] = it.sent_count;
			slot_recv[wr_slot] = it.recv_count;
			slot_rss[wr_slot]  = rss;
			sent_total += it.sent_count;
			recv_total += it.recv_count;
			rss_total  += rss;
			wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
			if (int'(it.obs_pdr) >= good_ratio)
				baseline = floor_div10(9 * baseline + 16 * rss + 5);
		endfunction

		function status_e classify_window();
			longint lhs, rhs;
			if (fill < WINDOW_DEPTH / 2)
				return ST_NONE;
			if (sent_total == 0 ||
			    longint'(recv_total) * 1024 >= longint'(healthy_ratio) * longint'(sent_total)) begin
				bad_count = 0;
				return ST_NONE;
			end
			lhs = longint'(baseline) * longint'(fill) - 16 * longint'(rss_total);
			rhs = 16 * longint'(drop_tol) * longint'(fill);
			if (lhs > rhs)
				return ST_FADING;
			if (bad_count < 255)
				bad_count++;
			return (bad_count >= persist) ? ST_CONFIRM : ST_SUSPECT;
		endfunction

		function void take_request(item_t it);
			report_t r;
			if (it.op == OP_CLASSIFY) begin
				r.status = classify_window();
			end else begin
				apply_push(it);
				r.status = ST_NONE;
			end
			r.fill = fill[4:0];
			expected_reports.push_back(r);
		endfunction

		function void note_error(string msg);
			if (mismatches < 10)
				$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endfunction

		function void check_report(logic [OUT_DATA_W-1:0] data);
			report_t want;
			status_e got_status;
			logic [4:0] got_fill;
			got_status = status_e'(data[1:0]);
			got_fill   = data[6:2];
			if (expected_reports.size() == 0) begin
				note_error($sformatf("unexpected result status=%0d fill=%0d",
				                     got_status, got_fill));
				return;
			end
			want = expected_reports.pop_front();
			if (got_status != want.status || got_fill != want.fill)
				note_error($sformatf("status exp=%0d got=%0d, fill exp=%0d got=%0d",
				                     want.status, got_status, want.fill, got_fill));
			else
				seen[int'(got_status)]++;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	link_jamming_classifier_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	link_scoreboard board = new();

	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;
	int sent_items = 0;
	int reg_loads  = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", board.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stall pattern: modes of random length, including always-ready stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(3);
				stall_left = $urandom_range(20, 120);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(3) != 0);
				2: m_axis_tready <= ($urandom_range(3) == 0);
				default: m_axis_tready <= stall_tick[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_report(m_axis_tdata);
	end

	function automatic item_t mk(op_e op, int pdr, int rss, int sent, int recv);
		item_t it;
		it.op         = op;
		it.obs_pdr    = 11'(pdr);
		it.obs_rss    = 12'(rss);
		it.sent_count = 8'(sent);
		it.recv_count = 8'(recv);
		return it;
	endfunction

	function automatic int clamp_rss(int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	// shaped random item: scene decides link quality and RSS relative to the baseline
	function automatic item_t make_item(scene_e scene, int classify_pct);
		item_t it;
		int center, sent;
		it.op         = ($urandom_range(99) < classify_pct) ? OP_CLASSIFY : OP_PUSH;
		it.obs_pdr    = 11'($urandom);
		it.obs_rss    = 12'($urandom);
		it.sent_count = 8'($urandom);
		it.recv_count = 8'($urandom);
		center = board.baseline / 16;
		sent = $urandom_range(100, 255);
		case (scene)
			SC_HEALTHY: begin
				sent = $urandom_range(1, 255);
				it.sent_count = 8'(sent);
				it.recv_count = 8'(sent - int'($urandom_range(0, sent / 8)));
				it.obs_pdr    = 11'($urandom_range(900, 1024));
				it.obs_rss    = 12'(clamp_rss(center + int'($urandom_range(0, 80)) - 40));
			end
			SC_JAMMED: begin
				it.sent_count = 8'(sent);
				it.recv_count = 8'($urandom_range(0, sent / 3));
				it.obs_pdr    = 11'($urandom_range(0, 400));
				it.obs_rss    = 12'(clamp_rss(center + int'($urandom_range(0, 60)) - 30));
			end
			SC_FADING: begin
				it.sent_count = 8'(sent);
				it.recv_count = 8'($urandom_range(0, sent / 3));
				it.obs_pdr    = 11'($urandom_range(0, 400));
				it.obs_rss    = 12'(clamp_rss(center - board.drop_tol
				                                 - int'($urandom_range(20, 400))));
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_item(item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {1'b0, it.recv_count, it.sent_count, it.obs_rss, it.obs_pdr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_request(it);
		sent_items++;
	endtask

	// hold off input until every outstanding result has been seen
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.write_cfg(idx, val);
	endtask

	task automatic load_regs(int good, int thr, int drop, int persist, int base, bit stray);
		cfg_write(REG_PDR_GOOD, CFG_W'(good));
		cfg_write(REG_PDR_THRESHOLD, CFG_W'(thr));
		cfg_write(REG_DROP_TOL, CFG_W'(drop));
		cfg_write(REG_PERSIST, CFG_W'(persist));
		cfg_write(REG_INIT_BASELINE, CFG_W'(base));
		if (stray)
			cfg_write(REG_UNUSED, CFG_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_loads++;
	endtask

	task automatic run_random(int count, int classify_pct);
		scene_e scene;
		int scene_left;
		int r;
		scene_left = 0;
		scene = SC_NOISE;
		repeat (count) begin
			if (scene_left == 0) begin
				r = $urandom_range(99);
				scene = (r < 35) ? SC_JAMMED : (r < 55) ? SC_FADING :
				        (r < 85) ? SC_HEALTHY : SC_NOISE;
				scene_left = $urandom_range(10, 30);
			end
			scene_left--;
			send_item(make_item(scene, classify_pct));
			if ($urandom_range(59) == 0)
				drain();
		end
	endtask

	initial begin
		item_t it;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short window, all-zero sent counts, field extremes, eviction, bad runs
		send_item(mk(OP_CLASSIFY, 0, 0, 0, 0));
		send_item(mk(OP_PUSH, 0, -2048, 0, 0));
		send_item(mk(OP_PUSH, 1024, 2047, 0, 0));
		send_item(mk(OP_PUSH, 2047, -1, 0, 255));
		send_item(mk(OP_PUSH, 922, 0, 0, 0));
		send_item(mk(OP_PUSH, 921, -800, 0, 0));
		send_item(mk(OP_PUSH, 1024, -800, 0, 0));
		send_item(mk(OP_PUSH, 0, -800, 0, 0));
		send_item(mk(OP_CLASSIFY, 2047, 2047, 255, 255));
		send_item(mk(OP_PUSH, 1024, -800, 0, 0));
		send_item(mk(OP_CLASSIFY, 0, 0, 0, 0));
		repeat (9)
			send_item(mk(OP_PUSH, 0, -800, 255, 0));
		repeat (3)
			send_item(mk(OP_CLASSIFY, 0, 0, 0, 0));
		send_item(mk(OP_PUSH, 1023, 2047, 255, 255));
		send_item(mk(OP_CLASSIFY, 0, 0, 0, 0));
		drain();

		// always averaging, health threshold of full delivery, widest tolerance
		load_regs(0, 1024, 4095, 1, -2048, 1'b0);
		run_random(40, 25);
		drain();

		// highest averaging and health thresholds, zero tolerance and zero persistence
		load_regs(2047, 2047, 0, 0, 2047, 1'b0);
		run_random(40, 25);
		drain();

		// long bad run to saturate the counter at the largest persistence
		load_regs(1024, 768, 4095, 255, -800, 1'b0);
		repeat (WINDOW_DEPTH) begin
			it = make_item(SC_JAMMED, 0);
			send_item(it);
		end
		repeat (260)
			send_item(make_item(SC_NOISE, 100));
		drain();

		// mid-range settings plus a write to an index with no register
		load_regs($urandom_range(700, 1000), $urandom_range(500, 900), $urandom_range(0, 400),
		          $urandom_range(2, 8), $urandom_range(0, 4095), 1'b1);
		run_random(40, 25);
		drain();

		repeat (10) @(posedge clk);
		$display("%0d transactions over %0d register settings", sent_items, reg_loads + 1);
		$display("statuses checked: none %0d, fading %0d, suspected %0d, confirmed %0d",
		         board.seen[0], board.seen[1], board.seen[2], board.seen[3]);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[link_jamming_classifier_core.f]
hw/rtl/ljc_pkg.sv
hw/rtl/ljc_front.sv
hw/rtl/ljc_back.sv
hw/rtl/link_jamming_classifier_core.sv
sim/tb_top.sv
